// ===== rtl/double_hash_key_value_map_unit_defines.svh =====
// assertion macros shared by the map unit modules
// each macro expects clk and rst in the scope of its use
`ifndef DOUBLE_HASH_KEY_VALUE_MAP_UNIT_DEFINES_SVH
`define DOUBLE_HASH_KEY_VALUE_MAP_UNIT_DEFINES_SVH

// condition holds at every edge out of reset
`define DHKV_ASSERT_NOW(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define DHKV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/dhkv_pkg.sv =====
package dhkv_pkg;

  // slot store geometry
  localparam int SLOTS = 256;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = IDX_W + 1;
  // live plus tombstone slots at which a fresh add reports full
  localparam int LOAD_LIMIT = (3 * SLOTS) / 4;

  // operation codes
  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_FIND   = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // result codes
  localparam logic [2:0] STATUS_ADDED     = 3'd0;
  localparam logic [2:0] STATUS_PRESENT   = 3'd1;
  localparam logic [2:0] STATUS_FOUND     = 3'd2;
  localparam logic [2:0] STATUS_NOT_FOUND = 3'd3;
  localparam logic [2:0] STATUS_REMOVED   = 3'd4;
  localparam logic [2:0] STATUS_FULL      = 3'd5;

  // slot marks
  localparam logic [1:0] MARK_FREE = 2'd0;
  localparam logic [1:0] MARK_LIVE = 2'd1;
  localparam logic [1:0] MARK_TOMB = 2'd2;

  // one slot of the store
  typedef struct packed {
    logic [1:0]  mark;
    logic [31:0] key;
    logic [15:0] fragment;
    logic [31:0] value;
  } entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic rd;
    logic check;
    logic finish;
    logic out_load;
  } dhkv_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic unused_op;
    logic probe_end;
  } dhkv_sts_t;

endpackage

// ===== rtl/double_hash_key_value_map_unit.sv =====
// channel  | handshake           | payload
// ---------+---------------------+------------------------------------------------
// request  | in_valid, in_ready  | func, key_id, key_frag, key_hash, value_in
// result   | out_valid, out_ready| status, value_out
//
// a request passes from transfer to result valid through a read and a check step
// per slot probed, then the finish step; each probe is one registered read of the
// slot store and one check; the unused operation code skips the probe and finishes
// a single request is in flight; the next is taken once the result is registered
// reset clears the written flags of all slots at once, no clearing pass
// a stalled result holds the block in its finish step until it is taken

module double_hash_key_value_map_unit import dhkv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [31:0] key_id,
  input  logic [15:0] key_frag,
  input  logic [31:0] key_hash,
  input  logic [31:0] value_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] value_out
);

  dhkv_cmd_t cmd;
  dhkv_sts_t sts;

  // request sequencer
  dhkv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // slot store and probe datapath
  dhkv_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .func         (func),
    .key_id       (key_id),
    .key_frag     (key_frag),
    .key_hash     (key_hash),
    .value_in     (value_in),
    .status       (status),
    .value_out    (value_out)
  );

endmodule

// ===== rtl/dhkv_ctrl.sv =====
`include "double_hash_key_value_map_unit_defines.svh"

module dhkv_ctrl import dhkv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dhkv_sts_t sts,
  output dhkv_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_READ   = 2'd1;
  localparam logic [1:0] S_CHECK  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == S_IDLE);

  // sequencing of one request
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = sts.unused_op ? S_FINISH : S_READ;
        end
      end
      S_READ: begin
        cmd.rd = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.probe_end) begin
          cmd.finish = 1'b1;
          state_next = S_FINISH;
        end else begin
          state_next = S_READ;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `DHKV_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `DHKV_ASSERT_NEXT(a_probe_end_exits, cmd.check && sts.probe_end, state == S_FINISH, "no exit")
  `DHKV_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid, "result dropped")

endmodule

// ===== rtl/dhkv_datapath.sv =====
`include "double_hash_key_value_map_unit_defines.svh"

module dhkv_datapath import dhkv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dhkv_cmd_t   cmd,
  output dhkv_sts_t   sts,
  input  logic [1:0]  func,
  input  logic [31:0] key_id,
  input  logic [15:0] key_frag,
  input  logic [31:0] key_hash,
  input  logic [31:0] value_in,
  output logic [2:0]  status,
  output logic [31:0] value_out
);

  // secondary hash for the probe step
  function automatic logic [31:0] mix_hash(input logic [31:0] h_in);
    logic [31:0] h;
    h = ~h_in + (h_in >> 23);
    h = h ^ (h << 12);
    h = h ^ (h >> 7);
    h = h ^ (h << 2);
    h = h ^ (h >> 20);
    return h;
  endfunction

  entry_t            entry_mem [SLOTS];
  logic [SLOTS-1:0]  valid_bits;
  entry_t            rd_entry;
  logic              rd_valid;

  logic [1:0]        func_r;
  logic [31:0]       key_r;
  logic [15:0]       frag_r;
  logic [31:0]       val_r;
  logic [IDX_W-1:0]  pos;
  logic [IDX_W-1:0]  step;
  logic [IDX_W-1:0]  probe_n;
  logic              have_cand;
  logic [IDX_W-1:0]  cand;
  logic [CNT_W-1:0]  live_count;
  logic [CNT_W-1:0]  tomb_count;
  logic [2:0]        res_status;
  logic [31:0]       res_value;

  logic [31:0]       mix_val;
  logic [1:0]        mark_eff;
  logic              is_live;
  logic              is_free;
  logic              is_tomb;
  logic              match;
  logic              last_probe;
  logic              have_eff;
  logic [IDX_W-1:0]  cand_eff;
  logic [CNT_W:0]    load_sum;
  logic              full;

  logic              wr_req;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  logic [2:0]        fin_status;
  logic [31:0]       fin_value;
  logic              live_inc;
  logic              live_dec;
  logic              tomb_inc;
  logic              tomb_dec;

  assign mix_val = mix_hash(key_hash);

  // probe evaluation on the registered slot read
  assign mark_eff   = rd_valid ? rd_entry.mark : MARK_FREE;
  assign is_live    = (mark_eff == MARK_LIVE);
  assign is_free    = (mark_eff == MARK_FREE);
  assign is_tomb    = !is_live && !is_free;
  assign match      = is_live && (rd_entry.key == key_r) && (rd_entry.fragment == frag_r);
  assign last_probe = &probe_n;
  assign have_eff   = have_cand || is_tomb;
  assign cand_eff   = have_cand ? cand : pos;
  assign load_sum   = {1'b0, live_count} + {1'b0, tomb_count};
  assign full       = load_sum >= (CNT_W + 1)'(LOAD_LIMIT);

  assign sts.unused_op = (func == FUNC_UNUSED);
  assign sts.probe_end = match || is_free || last_probe;

  // outcome of the request at the end of its probe
  always_comb begin
    wr_req     = 1'b0;
    wr_addr    = pos;
    wr_data    = '{mark: MARK_LIVE, key: key_r, fragment: frag_r, value: val_r};
    fin_status = STATUS_NOT_FOUND;
    fin_value  = '0;
    live_inc   = 1'b0;
    live_dec   = 1'b0;
    tomb_inc   = 1'b0;
    tomb_dec   = 1'b0;
    case (func_r)
      FUNC_ADD: begin
        if (match) begin
          fin_status = STATUS_PRESENT;
        end else if (is_free && !have_cand && full) begin
          fin_status = STATUS_FULL;
        end else if (is_free && !have_cand) begin
          wr_req     = 1'b1;
          live_inc   = 1'b1;
          fin_status = STATUS_ADDED;
        end else if (have_eff) begin
          // reuse the first tombstone on the path
          wr_req     = 1'b1;
          wr_addr    = cand_eff;
          live_inc   = 1'b1;
          tomb_dec   = 1'b1;
          fin_status = STATUS_ADDED;
        end else begin
          fin_status = STATUS_FULL;
        end
      end
      FUNC_FIND: begin
        if (match) begin
          fin_status = STATUS_FOUND;
          fin_value  = rd_entry.value;
        end
      end
      FUNC_REMOVE: begin
        if (match) begin
          wr_req     = 1'b1;
          wr_data    = rd_entry;
          wr_data.mark = MARK_TOMB;
          live_dec   = 1'b1;
          tomb_inc   = 1'b1;
          fin_status = STATUS_REMOVED;
          fin_value  = rd_entry.value;
        end
      end
      default: ;
    endcase
  end

  assign wr_en = cmd.finish && wr_req;

  // slot store, one write and one read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_entry <= entry_mem[pos];
      rd_valid <= valid_bits[pos];
    end
  end

  // written flags, a never-written slot reads as free
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (wr_en) begin
      valid_bits[wr_addr] <= 1'b1;
    end
  end

  // request registers and probe walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r     <= func;
      key_r      <= key_id;
      frag_r     <= key_frag;
      val_r      <= value_in;
      pos        <= key_hash[IDX_W-1:0];
      step       <= mix_val[IDX_W-1:0] | IDX_W'(1);
      probe_n    <= '0;
      res_status <= STATUS_NOT_FOUND;
      res_value  <= '0;
    end else if (cmd.check) begin
      pos     <= pos + step;
      probe_n <= probe_n + IDX_W'(1);
      if (is_tomb && !have_cand) begin
        cand <= pos;
      end
      if (cmd.finish) begin
        res_status <= fin_status;
        res_value  <= fin_value;
      end
    end
    if (cmd.out_load) begin
      status    <= res_status;
      value_out <= res_value;
    end
  end

  // tombstone candidate flag and occupancy counters
  always_ff @(posedge clk) begin
    if (rst) begin
      have_cand  <= 1'b0;
      live_count <= '0;
      tomb_count <= '0;
    end else begin
      if (cmd.load) begin
        have_cand <= 1'b0;
      end else if (cmd.check && is_tomb) begin
        have_cand <= 1'b1;
      end
      if (cmd.finish) begin
        if (live_inc) begin
          live_count <= live_count + CNT_W'(1);
        end else if (live_dec) begin
          live_count <= live_count - CNT_W'(1);
        end
        if (tomb_inc) begin
          tomb_count <= tomb_count + CNT_W'(1);
        end else if (tomb_dec) begin
          tomb_count <= tomb_count - CNT_W'(1);
        end
      end
    end
  end

  `DHKV_ASSERT_NOW(a_occupancy_bound, load_sum <= (CNT_W + 1)'(SLOTS), "occupancy over slot count")
  `DHKV_ASSERT_NEXT(a_written_valid, wr_en, valid_bits[$past(wr_addr)], "written slot not flagged")
  `DHKV_ASSERT_NEXT(a_finish_once, cmd.finish, !cmd.finish, "finish on two cycles in a row")

endmodule
